// File: hw/rtl/linked_queue_splice_engine_assert.svh
// ----------------------------------------------------------------------------
// linked queue splice engine assertion macros
// concurrent checks sampled on i_clk, held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef LINKED_QUEUE_SPLICE_ENGINE_ASSERT_SVH
`define LINKED_QUEUE_SPLICE_ENGINE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LQSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lqse check failed");

// consequent must hold in the cycle after the antecedent
`define LQSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lqse check failed");

`endif

// File: hw/rtl/lqse_pkg.sv
// ----------------------------------------------------------------------------
// lqse_pkg
// shared constants, types and helpers of the linked queue splice engine
// ----------------------------------------------------------------------------
package lqse_pkg;

    localparam int NUM_PEOPLE = 32;
    localparam int MEM_DEPTH  = 2 * NUM_PEOPLE;
    localparam int NODE_W     = $clog2(2 * NUM_PEOPLE + 1);
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int CNT_W      = $clog2(NUM_PEOPLE + 1);
    localparam int ID_W       = 6;

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ID_W-1:0]   t_id;

    // operation codes
    localparam logic [1:0] OP_MOVE   = 2'd0;
    localparam logic [1:0] OP_SPLICE = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;

    // status codes
    localparam logic [1:0] ST_APPLIED = 2'd0;
    localparam logic [1:0] ST_NOCHG   = 2'd1;
    localparam logic [1:0] ST_LISTED  = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MV_CHK,
        S_MV_UNLINK,
        S_MV_LINK_B,
        S_MV_LINK_A,
        S_SP_CHK,
        S_SP_CLOSE,
        S_SP_HEAD,
        S_SP_TAIL,
        S_LS_FIRST,
        S_LS_STEP,
        S_DONE
    } t_state;

    // one link store access per cycle: one read, one write
    typedef struct packed {
        logic  rd_en;
        t_addr rd_addr;
        logic  wr_en;
        t_addr wr_addr;
        t_node wr_data;
    } t_mem_req;

    // node n lives at address n-1
    function automatic t_addr node_addr(input t_node node);
        t_node dec;
        dec = node - t_node'(1);
        return dec[ADDR_W-1:0];
    endfunction

    function automatic logic is_person(input t_node node);
        return (node != '0) && (int'(node) <= NUM_PEOPLE);
    endfunction

    function automatic logic valid_id(input t_id id);
        return (id != '0) && (int'(id) <= NUM_PEOPLE);
    endfunction

    // link value after reset: person and its sentinel point at each other
    function automatic t_node rst_link(input t_addr addr);
        int n;
        n = int'(addr) + 1;
        if (n <= NUM_PEOPLE) begin
            return t_node'(n + NUM_PEOPLE);
        end
        return t_node'(n - NUM_PEOPLE);
    endfunction

endpackage

// File: hw/rtl/lqse_link_ram.sv
// ----------------------------------------------------------------------------
// lqse_link_ram
// one link store: synchronous ram, one read and one write a cycle, read
// data registered, per-entry valid bits give the reset links
// ----------------------------------------------------------------------------
module lqse_link_ram (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lqse_pkg::t_mem_req  i_req,
    output lqse_pkg::t_node     o_rd_data
);

    lqse_pkg::t_node                    r_mem [lqse_pkg::MEM_DEPTH];
    logic [lqse_pkg::MEM_DEPTH-1:0]     r_valid;
    lqse_pkg::t_node                    r_rd_data;
    lqse_pkg::t_addr                    r_rd_addr;
    logic                               r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_hit <= r_valid[i_req.rd_addr];
            end
        end
    end

    // untouched entries read as their reset link
    assign o_rd_data = r_rd_hit ? r_rd_data : lqse_pkg::rst_link(r_rd_addr);

endmodule

// File: hw/rtl/lqse_seq.sv
// ----------------------------------------------------------------------------
// lqse_seq
// operation sequencer: read, check and rewrite the link stores, walk a
// queue for listing, and hold the result register
// ----------------------------------------------------------------------------
module lqse_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_operation,
    input  lqse_pkg::t_id       i_first_id,
    input  lqse_pkg::t_id       i_second_id,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output lqse_pkg::t_id       o_member,
    output logic                o_last_of_run,
    output lqse_pkg::t_mem_req  o_next_req,
    output lqse_pkg::t_mem_req  o_prev_req,
    input  lqse_pkg::t_node     i_next_rd,
    input  lqse_pkg::t_node     i_prev_rd
);

    lqse_pkg::t_state r_state, n_state;
    lqse_pkg::t_node  r_a, n_a, r_b, n_b;
    lqse_pkg::t_node  r_n0, n_n0, r_n1, n_n1, r_n2, n_n2;
    lqse_pkg::t_cnt   r_cnt, n_cnt;
    logic [1:0]       r_status, n_status;

    logic             r_o_valid;
    logic [1:0]       r_o_status;
    lqse_pkg::t_id    r_o_member;
    logic             r_o_last;

    logic             w_accept;
    logic             w_out_free;
    logic             w_ok;
    logic             w_more;
    logic             w_emit;
    logic [1:0]       w_emit_status;
    lqse_pkg::t_id    w_emit_member;
    logic             w_emit_last;
    lqse_pkg::t_node  w_fa_node, w_fb_node, w_fa_sent, w_fb_sent;

    assign w_accept   = i_valid && (r_state == lqse_pkg::S_IDLE);
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_ok       = lqse_pkg::valid_id(i_first_id) && lqse_pkg::valid_id(i_second_id)
                        && (i_first_id != i_second_id);
    assign w_more     = lqse_pkg::is_person(i_next_rd)
                        && (r_cnt < lqse_pkg::t_cnt'(lqse_pkg::NUM_PEOPLE));

    assign w_fa_node = lqse_pkg::t_node'(i_first_id);
    assign w_fb_node = lqse_pkg::t_node'(i_second_id);
    assign w_fa_sent = lqse_pkg::t_node'(int'(i_first_id) + lqse_pkg::NUM_PEOPLE);
    assign w_fb_sent = lqse_pkg::t_node'(int'(i_second_id) + lqse_pkg::NUM_PEOPLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lqse_pkg::S_IDLE: begin
                if (w_accept) begin
                    priority if (i_operation == lqse_pkg::OP_MOVE && w_ok) begin
                        n_state = lqse_pkg::S_MV_CHK;
                    end else if (i_operation == lqse_pkg::OP_SPLICE && w_ok) begin
                        n_state = lqse_pkg::S_SP_CHK;
                    end else if (i_operation == lqse_pkg::OP_LIST
                                 && lqse_pkg::valid_id(i_first_id)) begin
                        n_state = lqse_pkg::S_LS_FIRST;
                    end else begin
                        n_state = lqse_pkg::S_DONE;
                    end
                end
            end
            lqse_pkg::S_MV_CHK: begin
                n_state = (i_next_rd == r_a) ? lqse_pkg::S_DONE : lqse_pkg::S_MV_UNLINK;
            end
            lqse_pkg::S_MV_UNLINK: n_state = lqse_pkg::S_MV_LINK_B;
            lqse_pkg::S_MV_LINK_B: n_state = lqse_pkg::S_MV_LINK_A;
            lqse_pkg::S_MV_LINK_A: n_state = lqse_pkg::S_DONE;
            lqse_pkg::S_SP_CHK: begin
                n_state = (i_next_rd == r_a) ? lqse_pkg::S_DONE : lqse_pkg::S_SP_CLOSE;
            end
            lqse_pkg::S_SP_CLOSE: n_state = lqse_pkg::S_SP_HEAD;
            lqse_pkg::S_SP_HEAD:  n_state = lqse_pkg::S_SP_TAIL;
            lqse_pkg::S_SP_TAIL:  n_state = lqse_pkg::S_DONE;
            lqse_pkg::S_LS_FIRST: begin
                n_state = lqse_pkg::is_person(i_next_rd) ? lqse_pkg::S_LS_STEP
                                                         : lqse_pkg::S_DONE;
            end
            lqse_pkg::S_LS_STEP: begin
                if (w_out_free && !w_more) begin
                    n_state = lqse_pkg::S_IDLE;
                end
            end
            lqse_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = lqse_pkg::S_IDLE;
                end
            end
            default: n_state = lqse_pkg::S_IDLE;
        endcase
    end

    // store accesses, working registers and result emission
    always_comb begin
        o_next_req    = '0;
        o_prev_req    = '0;
        n_a           = r_a;
        n_b           = r_b;
        n_n0          = r_n0;
        n_n1          = r_n1;
        n_n2          = r_n2;
        n_cnt         = r_cnt;
        n_status      = r_status;
        w_emit        = 1'b0;
        w_emit_status = r_status;
        w_emit_member = '0;
        w_emit_last   = 1'b1;
        unique case (r_state)
            lqse_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_status = lqse_pkg::ST_NOCHG;
                    priority if (i_operation == lqse_pkg::OP_MOVE && w_ok) begin
                        n_a                = w_fa_node;
                        n_b                = w_fb_node;
                        o_next_req.rd_en   = 1'b1;
                        o_next_req.rd_addr = lqse_pkg::node_addr(w_fb_node);
                        o_prev_req.rd_en   = 1'b1;
                        o_prev_req.rd_addr = lqse_pkg::node_addr(w_fa_node);
                    end else if (i_operation == lqse_pkg::OP_SPLICE && w_ok) begin
                        n_a                = w_fa_sent;
                        n_b                = w_fb_sent;
                        o_next_req.rd_en   = 1'b1;
                        o_next_req.rd_addr = lqse_pkg::node_addr(w_fa_sent);
                        o_prev_req.rd_en   = 1'b1;
                        o_prev_req.rd_addr = lqse_pkg::node_addr(w_fa_sent);
                    end else if (i_operation == lqse_pkg::OP_LIST
                                 && lqse_pkg::valid_id(i_first_id)) begin
                        n_a                = w_fa_sent;
                        o_next_req.rd_en   = 1'b1;
                        o_next_req.rd_addr = lqse_pkg::node_addr(w_fa_sent);
                    end else begin
                        n_a = r_a;
                    end
                end
            end
            // n0 = successor of b, n1 = predecessor of a
            lqse_pkg::S_MV_CHK: begin
                n_n0 = i_next_rd;
                n_n1 = i_prev_rd;
                if (i_next_rd != r_a) begin
                    o_next_req.rd_en   = 1'b1;
                    o_next_req.rd_addr = lqse_pkg::node_addr(r_a);
                end
            end
            // unlink a; b's successor becomes a's old successor if b preceded a
            lqse_pkg::S_MV_UNLINK: begin
                o_next_req.wr_en   = 1'b1;
                o_next_req.wr_addr = lqse_pkg::node_addr(r_n1);
                o_next_req.wr_data = i_next_rd;
                o_prev_req.wr_en   = 1'b1;
                o_prev_req.wr_addr = lqse_pkg::node_addr(i_next_rd);
                o_prev_req.wr_data = r_n1;
                n_n2 = (r_n1 == r_b) ? i_next_rd : r_n0;
            end
            lqse_pkg::S_MV_LINK_B: begin
                o_next_req.wr_en   = 1'b1;
                o_next_req.wr_addr = lqse_pkg::node_addr(r_b);
                o_next_req.wr_data = r_a;
                o_prev_req.wr_en   = 1'b1;
                o_prev_req.wr_addr = lqse_pkg::node_addr(r_a);
                o_prev_req.wr_data = r_b;
            end
            lqse_pkg::S_MV_LINK_A: begin
                o_next_req.wr_en   = 1'b1;
                o_next_req.wr_addr = lqse_pkg::node_addr(r_a);
                o_next_req.wr_data = r_n2;
                o_prev_req.wr_en   = 1'b1;
                o_prev_req.wr_addr = lqse_pkg::node_addr(r_n2);
                o_prev_req.wr_data = r_a;
                n_status = lqse_pkg::ST_APPLIED;
            end
            // n0 = first of source, n1 = last of source
            lqse_pkg::S_SP_CHK: begin
                n_n0 = i_next_rd;
                n_n1 = i_prev_rd;
                if (i_next_rd != r_a) begin
                    o_prev_req.rd_en   = 1'b1;
                    o_prev_req.rd_addr = lqse_pkg::node_addr(r_b);
                end
            end
            // n2 = current end of destination; source sentinel closes on itself
            lqse_pkg::S_SP_CLOSE: begin
                n_n2 = i_prev_rd;
                o_next_req.wr_en   = 1'b1;
                o_next_req.wr_addr = lqse_pkg::node_addr(r_a);
                o_next_req.wr_data = r_a;
                o_prev_req.wr_en   = 1'b1;
                o_prev_req.wr_addr = lqse_pkg::node_addr(r_a);
                o_prev_req.wr_data = r_a;
            end
            lqse_pkg::S_SP_HEAD: begin
                o_next_req.wr_en   = 1'b1;
                o_next_req.wr_addr = lqse_pkg::node_addr(r_n2);
                o_next_req.wr_data = r_n0;
                o_prev_req.wr_en   = 1'b1;
                o_prev_req.wr_addr = lqse_pkg::node_addr(r_n0);
                o_prev_req.wr_data = r_n2;
            end
            lqse_pkg::S_SP_TAIL: begin
                o_next_req.wr_en   = 1'b1;
                o_next_req.wr_addr = lqse_pkg::node_addr(r_n1);
                o_next_req.wr_data = r_b;
                o_prev_req.wr_en   = 1'b1;
                o_prev_req.wr_addr = lqse_pkg::node_addr(r_b);
                o_prev_req.wr_data = r_n1;
                n_status = lqse_pkg::ST_APPLIED;
            end
            lqse_pkg::S_LS_FIRST: begin
                if (lqse_pkg::is_person(i_next_rd)) begin
                    n_n0               = i_next_rd;
                    n_cnt              = lqse_pkg::t_cnt'(1);
                    o_next_req.rd_en   = 1'b1;
                    o_next_req.rd_addr = lqse_pkg::node_addr(i_next_rd);
                end else begin
                    n_status = lqse_pkg::ST_EMPTY;
                end
            end
            // n0 = member on hand, read data = member after it
            lqse_pkg::S_LS_STEP: begin
                if (w_out_free) begin
                    w_emit        = 1'b1;
                    w_emit_status = lqse_pkg::ST_LISTED;
                    w_emit_member = r_n0[lqse_pkg::ID_W-1:0];
                    w_emit_last   = !w_more;
                    if (w_more) begin
                        n_n0               = i_next_rd;
                        n_cnt              = r_cnt + lqse_pkg::t_cnt'(1);
                        o_next_req.rd_en   = 1'b1;
                        o_next_req.rd_addr = lqse_pkg::node_addr(i_next_rd);
                    end
                end
            end
            lqse_pkg::S_DONE: begin
                w_emit = w_out_free;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lqse_pkg::S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_n0     <= n_n0;
        r_n1     <= n_n1;
        r_n2     <= n_n2;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        if (w_emit) begin
            r_o_status <= w_emit_status;
            r_o_member <= w_emit_member;
            r_o_last   <= w_emit_last;
        end
    end

    assign o_stall       = (r_state != lqse_pkg::S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_member      = r_o_member;
    assign o_last_of_run = r_o_last;

endmodule

// File: hw/rtl/linked_queue_splice_engine.sv
// ----------------------------------------------------------------------------
// linked_queue_splice_engine: moves people, splices and lists circular queues
// move and splice handle one item at a time, from transfer in to result
// listing walks from its sentinel, then one member per cycle unless stalled
// rate is set by the dependent read-then-write chain on the two link rams
// sync reset clears per-entry valid bits: each person alone, no clearing pass
// ----------------------------------------------------------------------------
module linked_queue_splice_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_operation,
    input  lqse_pkg::t_id       i_first_id,
    input  lqse_pkg::t_id       i_second_id,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output lqse_pkg::t_id       o_member,
    output logic                o_last_of_run
);

    // request and read data of the successor and predecessor link rams
    lqse_pkg::t_mem_req w_next_req;
    lqse_pkg::t_mem_req w_prev_req;
    lqse_pkg::t_node    w_next_rd;
    lqse_pkg::t_node    w_prev_rd;

    // sequencer: takes one transfer at a time, the result register lets the
    // next transfer in while the last result is still waiting downstream
    lqse_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_first_id    (i_first_id),
        .i_second_id   (i_second_id),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_member      (o_member),
        .o_last_of_run (o_last_of_run),
        .o_next_req    (w_next_req),
        .o_prev_req    (w_prev_req),
        .i_next_rd     (w_next_rd),
        .i_prev_rd     (w_prev_rd)
    );

    // successor links, one entry per node
    lqse_link_ram u_next_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_next_req),
        .o_rd_data (w_next_rd)
    );

    // predecessor links, same layout and reset pattern
    lqse_link_ram u_prev_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_prev_req),
        .o_rd_data (w_prev_rd)
    );

endmodule

// File: hw/rtl/lqse_checker.sv
// ----------------------------------------------------------------------------
// lqse_port_checker
// port-level checks of the linked queue splice engine, bound to the top level
// ----------------------------------------------------------------------------
`include "linked_queue_splice_engine_assert.svh"

module lqse_port_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [1:0]          o_status,
    input lqse_pkg::t_id       o_member,
    input logic                o_last_of_run
);

    // whole result payload as one word
    logic [lqse_pkg::ID_W+2:0] w_out_word;

    assign w_out_word = {o_status, o_member, o_last_of_run};

    // a held result keeps its payload
    `LQSE_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(w_out_word))

    // one item at a time: a transfer in closes the input side
    `LQSE_ASSERT_NEXT(a_one_item, i_valid && !o_stall, o_stall)

    // only listed members carry a person number
    `LQSE_ASSERT_NOW(a_member_zero, o_valid && (o_status != lqse_pkg::ST_LISTED), o_member == '0)

    // every result that is not a listed member ends its run
    `LQSE_ASSERT_NOW(a_single_last, o_valid && (o_status != lqse_pkg::ST_LISTED), o_last_of_run)

endmodule

bind linked_queue_splice_engine lqse_port_checker u_lqse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_member      (o_member),
    .o_last_of_run (o_last_of_run)
);

// File: bench/lqse_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lqse_checker
// keeps its own copy of the queue links, predicts every result of the
// linked queue splice engine and compares each result transfer with it
// ----------------------------------------------------------------------------
module lqse_checker
    import lqse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_stall,
    input  logic [1:0] i_operation,
    input  t_id        i_first_id,
    input  t_id        i_second_id,
    input  logic       i_rsp_valid,
    input  logic       i_rsp_stall,
    input  logic [1:0] i_status,
    input  t_id        i_member,
    input  logic       i_last_of_run,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [1:0] status;
        t_id        member;
        logic       last_of_run;
    } t_result;

    t_result expected_results[$];
    t_node   next_of [0:2*NUM_PEOPLE];
    t_node   prev_of [0:2*NUM_PEOPLE];
    t_result seen;
    t_result want;
    int      mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // one line per mismatch, printing capped to keep the log short
    task automatic report(input string msg);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function automatic logic is_person_id(input int id);
        return (id >= 1) && (id <= NUM_PEOPLE);
    endfunction

    function automatic void tie(input int left, input int right);
        next_of[left]  = t_node'(right);
        prev_of[right] = t_node'(left);
    endfunction

    function automatic void reset_links();
        for (int i = 1; i <= NUM_PEOPLE; i++) begin
            tie(NUM_PEOPLE + i, i);
            tie(i, NUM_PEOPLE + i);
        end
        next_of[0] = '0;
        prev_of[0] = '0;
    endfunction

    function automatic logic [1:0] move_behind(input int who, input int target);
        int was_prev;
        int was_next;
        int target_next;
        if (int'(next_of[target]) == who) begin
            return ST_NOCHG;
        end
        was_prev = int'(prev_of[who]);
        was_next = int'(next_of[who]);
        tie(was_prev, was_next);
        // successor of the target is read after the unlink
        target_next = int'(next_of[target]);
        tie(target, who);
        tie(who, target_next);
        return ST_APPLIED;
    endfunction

    function automatic logic [1:0] splice_onto(input int src, input int dst);
        int src_head;
        int dst_head;
        int front;
        int back;
        int dst_back;
        src_head = NUM_PEOPLE + src;
        dst_head = NUM_PEOPLE + dst;
        if (int'(next_of[src_head]) == src_head) begin
            return ST_NOCHG;
        end
        front    = int'(next_of[src_head]);
        back     = int'(prev_of[src_head]);
        dst_back = int'(prev_of[dst_head]);
        tie(src_head, src_head);
        tie(dst_back, front);
        tie(back, dst_head);
        return ST_APPLIED;
    endfunction

    function automatic void push_result(input logic [1:0] st, input int mem, input logic last);
        t_result r;
        r.status      = st;
        r.member      = t_id'(mem);
        r.last_of_run = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_transfer(input logic [1:0] op, input t_id a, input t_id b);
        int         ia;
        int         ib;
        int         node;
        int         count;
        logic [1:0] st;
        ia = int'(a);
        ib = int'(b);
        if (op == OP_MOVE || op == OP_SPLICE) begin
            st = ST_NOCHG;
            if (is_person_id(ia) && is_person_id(ib) && ia != ib) begin
                if (op == OP_MOVE) begin
                    st = move_behind(ia, ib);
                end else begin
                    st = splice_onto(ia, ib);
                end
            end
            push_result(st, 0, 1'b1);
        end else if (op == OP_LIST) begin
            if (!is_person_id(ia)) begin
                push_result(ST_NOCHG, 0, 1'b1);
            end else begin
                count = 0;
                node  = int'(next_of[NUM_PEOPLE + ia]);
                while (count < NUM_PEOPLE && is_person_id(node)) begin
                    count++;
                    node = int'(next_of[node]);
                end
                if (count == 0) begin
                    push_result(ST_EMPTY, 0, 1'b1);
                end else begin
                    node = int'(next_of[NUM_PEOPLE + ia]);
                    for (int k = 0; k < count; k++) begin
                        push_result(ST_LISTED, node, k == count - 1);
                        node = int'(next_of[node]);
                    end
                end
            end
        end else begin
            push_result(ST_NOCHG, 0, 1'b1);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_links();
            expected_results.delete();
        end else begin
            // results first: they always belong to items taken earlier
            if (i_rsp_valid && !i_rsp_stall) begin
                seen.status      = i_status;
                seen.member      = i_member;
                seen.last_of_run = i_last_of_run;
                if (expected_results.size() == 0) begin
                    report($sformatf("result with nothing expected: status %0d member %0d",
                                     seen.status, seen.member));
                end else begin
                    want = expected_results.pop_front();
                    if (seen.status != want.status) begin
                        report($sformatf("status got %0d expected %0d",
                                         seen.status, want.status));
                    end
                    if (seen.member != want.member) begin
                        report($sformatf("member got %0d expected %0d",
                                         seen.member, want.member));
                    end
                    if (seen.last_of_run != want.last_of_run) begin
                        report($sformatf("last_of_run got %0d expected %0d",
                                         seen.last_of_run, want.last_of_run));
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                predict_transfer(i_operation, i_first_id, i_second_id);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives moves, splices and listings into the linked queue splice engine
// under several idle and stall mixes; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_top;
    import lqse_pkg::*;

    // code the block treats as no change
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // length of the long receiver hold-off, in cycles
    localparam int LONG_HOLD = 300;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_operation;
    t_id        i_first_id;
    t_id        i_second_id;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_status;
    t_id        o_member;
    logic       o_last_of_run;

    int fail_count;
    int pending;

    // idle mix of each side, in percent of cycles
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // hold-off request from the stimulus, served by the receiver process
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;

    linked_queue_splice_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_first_id    (i_first_id),
        .i_second_id   (i_second_id),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_member      (o_member),
        .o_last_of_run (o_last_of_run)
    );

    lqse_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_operation   (i_operation),
        .i_first_id    (i_first_id),
        .i_second_id   (i_second_id),
        .i_rsp_valid   (o_valid),
        .i_rsp_stall   (i_stall),
        .i_status      (o_status),
        .i_member      (o_member),
        .i_last_of_run (o_last_of_run),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side: random stall, or a long hold-off counted here
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // offer one item, with random idle cycles in front, and wait for its transfer;
    // valid stays high afterwards so back-to-back items need no second assignment
    task automatic send_item(input logic [1:0] op, input int a, input int b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_first_id  <= t_id'(a);
        i_second_id <= t_id'(b);
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    // mostly well-formed operations on real people and queues,
    // the rest is noise over the whole field ranges
    task automatic send_random();
        int         pick;
        logic [1:0] op;
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_item(OP_MOVE, $urandom_range(NUM_PEOPLE, 1), $urandom_range(NUM_PEOPLE, 1));
        end else if (pick < 55) begin
            send_item(OP_SPLICE, $urandom_range(NUM_PEOPLE, 1), $urandom_range(NUM_PEOPLE, 1));
        end else if (pick < 85) begin
            send_item(OP_LIST, $urandom_range(NUM_PEOPLE, 1), $urandom_range(63));
        end else begin
            op = 2'($urandom_range(3));
            send_item(op, $urandom_range(63), $urandom_range(63));
        end
    endtask

    // sender pause: drop valid and wait until every expected result is back;
    // pending is registered, so the first edge lets the last transfer show up
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= OP_MOVE;
        i_first_id  <= '0;
        i_second_id <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every operation, id extremes and each no-change case
        send_item(OP_LIST, 1, 0);            // single member after reset
        send_item(OP_LIST, NUM_PEOPLE, 63);  // top queue, second id ignored
        send_item(OP_LIST, 0, 5);            // queue id below range
        send_item(OP_LIST, 63, 63);          // queue id above range
        send_item(OP_MOVE, 1, 2);            // person 1 behind person 2
        send_item(OP_MOVE, 1, 2);            // already in place
        send_item(OP_MOVE, 2, 1);            // neighbour swap inside queue 2
        send_item(OP_MOVE, 5, 5);            // same person twice
        send_item(OP_MOVE, 0, 3);            // person id out of range
        send_item(OP_MOVE, 3, 63);
        send_item(OP_MOVE, 33, 3);
        send_item(OP_SPLICE, 3, 4);          // queue 3 onto queue 4
        send_item(OP_SPLICE, 3, 4);          // source now empty
        send_item(OP_SPLICE, 4, 4);          // same queue twice
        send_item(OP_SPLICE, 0, 4);
        send_item(OP_SPLICE, 4, 40);
        send_item(OP_SPLICE, 2, 1);          // queue 1 was left empty
        send_item(OP_SPLICE, NUM_PEOPLE, 1);
        send_item(OP_LIST, 1, 21);           // three members
        send_item(OP_LIST, 2, 42);           // empty queue
        send_item(OP_LIST, 4, 0);
        send_item(OP_UNUSED, 21, 42);        // unused code
        send_item(OP_UNUSED, 63, 0);
        send_item(OP_UNUSED, 42, 21);
        drain();

        // random items over four idle mixes, draining between them
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1: begin
                    send_idle_pct = 69;
                    recv_idle_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 69;
                end
                default: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 28;
                end
            endcase
            repeat (40) send_random();
            drain();
        end

        // long receiver hold-off while the sender keeps offering: gather every
        // queue into queue 1, then list all people in one run
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req++;
        for (int q = 2; q <= NUM_PEOPLE; q++) begin
            send_item(OP_SPLICE, q, 1);
        end
        send_item(OP_LIST, 1, 0);
        drain();

        // scatter again from the full queue and finish on a mixed pattern
        send_idle_pct = 28;
        recv_idle_pct = 28;
        repeat (14) send_random();
        drain();

        // let any trailing activity settle
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/lqse_pkg.sv
hw/rtl/lqse_link_ram.sv
hw/rtl/lqse_seq.sv
hw/rtl/linked_queue_splice_engine.sv
hw/rtl/lqse_checker.sv
bench/lqse_checker.sv
bench/tb_top.sv
